// File: sv/sdsc_pkg.sv
package sdsc_pkg;

    typedef logic [7:0] t_byte;
    typedef logic [6:0] t_count;
    typedef logic [5:0] t_int_len;

    // Parse position within the signature
    typedef enum logic [2:0] {
        PH_SEQ_TAG  = 3'd0,
        PH_SEQ_LEN  = 3'd1,
        PH_INT_TAG  = 3'd2,
        PH_INT_LEN  = 3'd3,
        PH_INT_BODY = 3'd4,
        PH_DONE     = 3'd5
    } t_phase;

    localparam t_count   MAX_SIG_BYTES = 7'd72;
    localparam t_count   MIN_SIG_BYTES = 7'd8;
    localparam t_count   HDR_BYTES     = 7'd2;
    localparam t_byte    TAG_SEQUENCE  = 8'h30;
    localparam t_byte    TAG_INTEGER   = 8'h02;
    localparam t_int_len INT_LEN_MAX   = 6'd33;

endpackage

// File: sv/sdsc_in_if.sv
interface sdsc_in_if;
    import sdsc_pkg::*;

    logic  valid;
    logic  ready;
    t_byte sig_byte;
    logic  final_byte;

    modport source (output valid, output sig_byte, output final_byte, input ready);
    modport sink   (input valid, input sig_byte, input final_byte, output ready);
endinterface

// File: sv/sdsc_out_if.sv
interface sdsc_out_if;
    import sdsc_pkg::*;

    logic valid;
    logic ready;
    logic sig_ok;

    modport source (output valid, output sig_ok, input ready);
    modport sink   (input valid, input sig_ok, output ready);
endinterface

// File: sv/strict_der_signature_checker_core.sv
// Strict DER checker for ECDSA signatures.
// i_sig carries the signature one byte per transfer (sig_byte), with
// final_byte high on its last byte. o_res gives one transfer per
// signature, on its final byte: sig_ok is 1 when the SEQUENCE of two
// INTEGERs is strictly well formed and 0 otherwise.
// Throughput: one byte per cycle; the parse of each byte is a single
// step of the state update between the input register and the result
// register, so bytes of consecutive signatures stream without gaps
// unless a final byte is held back (see Stall).
// Path: a verdict goes from the input register to the result register.
// Stall: while a result waits in the result register, bytes that are not
// final still go on; a further final byte waits in the input register and
// i_sig.ready drops until the pending result has been taken.
// Reset: i_rst_n low at a rising edge empties both registers and returns
// the parse to the sequence tag; the parse also restarts after every
// final byte.
module strict_der_signature_checker_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    sdsc_in_if.sink           i_sig,
    sdsc_out_if.source        o_res
);
    import sdsc_pkg::*;

    // Input register
    logic     r_in_valid;
    t_byte    r_in_byte;
    logic     r_in_final;

    // Parse state
    t_phase   r_phase,      n_phase;
    t_count   r_bytes_seen, n_bytes_seen;
    t_count   r_seq_len,    n_seq_len;
    t_int_len r_int_left,   n_int_left;
    t_int_len r_int_len,    n_int_len;
    t_byte    r_int_lead,   n_int_lead;
    logic     r_second_int, n_second_int;
    logic     r_fault,      n_fault;

    // Result register
    logic     r_out_valid;
    logic     r_sig_ok;

    logic     advance;
    logic     load_res;
    logic     sig_ok;
    logic     first_body;
    logic     second_body;
    logic     body_bad;
    t_int_len left_dec;

    // Hold a final byte only while the result register is occupied
    assign advance     = r_in_valid && (!r_in_final || !r_out_valid || o_res.ready);
    assign load_res    = advance && r_in_final;
    assign i_sig.ready = !r_in_valid || advance;

    assign o_res.valid  = r_out_valid;
    assign o_res.sig_ok = r_sig_ok;

    // Integer body checks: sign of the lead byte, zero lead of a full-width integer, padding of the second
    assign first_body  = (r_int_left == r_int_len);
    assign second_body = (({1'b0, r_int_left} + 7'd1) == {1'b0, r_int_len});
    assign left_dec    = r_int_left - 6'd1;
    always_comb begin
        if (first_body) begin
            body_bad = r_in_byte[7] ||
                       ((r_int_len == INT_LEN_MAX) && (r_in_byte != 8'd0));
        end else begin
            body_bad = second_body && (r_int_lead == 8'd0) && !r_in_byte[7];
        end
    end

    // Advance the parse by one byte
    always_comb begin
        n_phase      = r_phase;
        n_bytes_seen = r_bytes_seen;
        n_seq_len    = r_seq_len;
        n_int_left   = r_int_left;
        n_int_len    = r_int_len;
        n_int_lead   = r_int_lead;
        n_second_int = r_second_int;
        n_fault      = r_fault;
        if (r_bytes_seen >= MAX_SIG_BYTES) begin
            n_fault = 1'b1;
        end else begin
            n_bytes_seen = r_bytes_seen + 7'd1;
            if (!r_fault) begin
                unique case (r_phase)
                    PH_SEQ_TAG: begin
                        if (r_in_byte != TAG_SEQUENCE) n_fault = 1'b1;
                        else n_phase = PH_SEQ_LEN;
                    end
                    PH_SEQ_LEN: begin
                        if (r_in_byte[7]) begin
                            n_fault = 1'b1;
                        end else begin
                            n_seq_len = r_in_byte[6:0];
                            n_phase   = PH_INT_TAG;
                        end
                    end
                    PH_INT_TAG: begin
                        if (r_in_byte != TAG_INTEGER) n_fault = 1'b1;
                        else n_phase = PH_INT_LEN;
                    end
                    PH_INT_LEN: begin
                        if ((r_in_byte == 8'd0) || (r_in_byte > {2'b00, INT_LEN_MAX})) begin
                            n_fault = 1'b1;
                        end else begin
                            n_int_len  = r_in_byte[5:0];
                            n_int_left = r_in_byte[5:0];
                            n_phase    = PH_INT_BODY;
                        end
                    end
                    PH_INT_BODY: begin
                        if (body_bad) begin
                            n_fault = 1'b1;
                        end else begin
                            if (first_body) n_int_lead = r_in_byte;
                            n_int_left = left_dec;
                            if (left_dec == 6'd0) begin
                                if (!r_second_int) begin
                                    n_second_int = 1'b1;
                                    n_phase      = PH_INT_TAG;
                                end else begin
                                    n_phase = PH_DONE;
                                end
                            end
                        end
                    end
                    default: n_fault = 1'b1;
                endcase
            end
        end
        sig_ok = !n_fault && (n_phase == PH_DONE) && (n_bytes_seen >= MIN_SIG_BYTES) &&
                 ((n_bytes_seen - HDR_BYTES) == n_seq_len);
    end

    // Input register: take a transfer whenever the stage moves on or is empty
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_sig.ready) begin
            r_in_valid <= i_sig.valid;
        end
        if (i_sig.ready && i_sig.valid) begin
            r_in_byte  <= i_sig.sig_byte;
            r_in_final <= i_sig.final_byte;
        end
    end

    // Parse state: restart after each final byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || load_res) begin
            r_phase      <= PH_SEQ_TAG;
            r_bytes_seen <= '0;
            r_seq_len    <= '0;
            r_int_left   <= '0;
            r_int_len    <= '0;
            r_int_lead   <= '0;
            r_second_int <= 1'b0;
            r_fault      <= 1'b0;
        end else if (advance) begin
            r_phase      <= n_phase;
            r_bytes_seen <= n_bytes_seen;
            r_seq_len    <= n_seq_len;
            r_int_left   <= n_int_left;
            r_int_len    <= n_int_len;
            r_int_lead   <= n_int_lead;
            r_second_int <= n_second_int;
            r_fault      <= n_fault;
        end
    end

    // Result register: load on a final byte, drop once transferred
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_res) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
        if (load_res) begin
            r_sig_ok <= sig_ok;
        end
    end

    // Checks
    a_count_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bytes_seen <= MAX_SIG_BYTES)
        else $error("byte counter beyond its ceiling");

    a_final_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load_res |=> r_out_valid)
        else $error("final byte produced no result");

    a_fault_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fault && !load_res) |=> r_fault)
        else $error("fault cleared within a signature");

    a_body_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_INT_BODY) |-> ((r_int_left != 6'd0) && (r_int_left <= r_int_len)))
        else $error("integer body count out of range");

endmodule

// File: tb/sv/sdsc_verdict_checker.sv
`timescale 1ns / 100ps

module sdsc_verdict_checker (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic           i_in_ready,
    input  sdsc_pkg::t_byte i_sig_byte,
    input  logic           i_final_byte,
    input  logic           i_out_valid,
    input  logic           i_out_ready,
    input  logic           i_sig_ok,
    output int             o_fail_count,
    output int             o_pending,
    output int             o_ok_count,
    output int             o_bad_count
);
    import sdsc_pkg::*;

    // Shadow copy of the parse state
    t_phase   parse_phase;
    t_count   seen_bytes;
    t_count   declared_len;
    t_int_len body_left;
    t_int_len body_len;
    t_byte    body_lead;
    logic     on_second;
    logic     broken;

    // Verdicts owed by the block, oldest first
    logic     verdict_q[$];

    task automatic restart_parse();
        parse_phase  = PH_SEQ_TAG;
        seen_bytes   = '0;
        declared_len = '0;
        body_left    = '0;
        body_len     = '0;
        body_lead    = '0;
        on_second    = 1'b0;
        broken       = 1'b0;
    endtask

    // Advance the parse by one byte of a signature that has no fault yet
    task automatic parse_der_byte(input t_byte b);
        logic bad;
        bad = 1'b0;
        case (parse_phase)
            PH_SEQ_TAG: begin
                if (b != TAG_SEQUENCE) bad = 1'b1;
                else parse_phase = PH_SEQ_LEN;
            end
            PH_SEQ_LEN: begin
                // long-form lengths are not allowed
                if (b[7]) bad = 1'b1;
                else begin
                    declared_len = b[6:0];
                    parse_phase  = PH_INT_TAG;
                end
            end
            PH_INT_TAG: begin
                if (b != TAG_INTEGER) bad = 1'b1;
                else parse_phase = PH_INT_LEN;
            end
            PH_INT_LEN: begin
                if (b == 8'h00 || b > 8'(INT_LEN_MAX)) bad = 1'b1;
                else begin
                    body_len    = b[5:0];
                    body_left   = b[5:0];
                    parse_phase = PH_INT_BODY;
                end
            end
            PH_INT_BODY: begin
                if (body_left == body_len) begin
                    // lead byte: no sign bit, and a full-width integer leads with zero
                    if (b[7]) bad = 1'b1;
                    else if (body_len == INT_LEN_MAX && b != 8'h00) bad = 1'b1;
                    else body_lead = b;
                end else if (t_int_len'(body_left + 6'd1) == body_len) begin
                    // a zero lead is only allowed as sign padding
                    if (body_lead == 8'h00 && !b[7]) bad = 1'b1;
                end
                if (!bad) begin
                    body_left = body_left - 6'd1;
                    if (body_left == '0) begin
                        if (!on_second) begin
                            on_second   = 1'b1;
                            parse_phase = PH_INT_TAG;
                        end else begin
                            parse_phase = PH_DONE;
                        end
                    end
                end
            end
            default: bad = 1'b1;
        endcase
        if (bad) broken = 1'b1;
    endtask

    // Compare results, then fold in the byte moved by this edge
    always @(posedge i_clk) begin : track
        logic owed;
        logic verdict;
        if (!i_rst_n) begin
            restart_parse();
            verdict_q.delete();
            o_fail_count = 0;
            o_ok_count   = 0;
            o_bad_count  = 0;
        end else begin
            // a result always belongs to a final byte from an earlier edge
            if (i_out_valid && i_out_ready) begin
                if (i_sig_ok === 1'b1) o_ok_count = o_ok_count + 1;
                else o_bad_count = o_bad_count + 1;
                if (verdict_q.size() == 0) begin
                    $error("sig_ok: expected none, actual %0b", i_sig_ok);
                    o_fail_count = o_fail_count + 1;
                end else begin
                    owed = verdict_q.pop_front();
                    if (i_sig_ok !== owed) begin
                        $error("sig_ok: expected %0b, actual %0b", owed, i_sig_ok);
                        o_fail_count = o_fail_count + 1;
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                // saturate the count and flag an overlong stream
                if (seen_bytes >= MAX_SIG_BYTES) broken = 1'b1;
                else begin
                    seen_bytes = seen_bytes + 7'd1;
                    if (!broken) parse_der_byte(i_sig_byte);
                end
                if (i_final_byte) begin
                    verdict = !broken && parse_phase == PH_DONE &&
                              seen_bytes >= MIN_SIG_BYTES &&
                              t_count'(seen_bytes - HDR_BYTES) == declared_len;
                    verdict_q.push_back(verdict);
                    restart_parse();
                end
            end
        end
        o_pending = verdict_q.size();
    end

endmodule

// File: tb/sv/strict_der_signature_checker_core_tb.sv
`timescale 1ns / 100ps

module strict_der_signature_checker_core_tb;
    import sdsc_pkg::*;

    localparam int QUIET_LIMIT = 2000;
    localparam int SETTLE_CYCLES = 8;

    typedef struct packed {
        t_byte value;
        logic  last;
    } t_sig_item;

    // Ways of spoiling an otherwise well-formed signature
    typedef enum int {
        FLAW_SEQ_TAG,
        FLAW_SEQ_LEN,
        FLAW_LONG_FORM,
        FLAW_INT_TAG,
        FLAW_INT_LEN,
        FLAW_NEGATIVE,
        FLAW_PADDING,
        FLAW_WIDE_LEAD,
        FLAW_TRUNCATE,
        FLAW_TRAILING,
        FLAW_OVERLONG
    } t_flaw;

    logic i_clk;
    logic i_rst_n;

    sdsc_in_if  sig_ch();
    sdsc_out_if res_ch();

    t_sig_item byte_stream[$];
    int src_idle_pct = 29;
    int snk_idle_pct = 52;
    int sig_total = 0;
    int byte_total = 0;
    int quiet_cycles = 0;
    int fail_count;
    int pending;
    int ok_count;
    int bad_count;

    strict_der_signature_checker_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sig   (sig_ch),
        .o_res   (res_ch)
    );

    sdsc_verdict_checker verdicts (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (sig_ch.valid),
        .i_in_ready   (sig_ch.ready),
        .i_sig_byte   (sig_ch.sig_byte),
        .i_final_byte (sig_ch.final_byte),
        .i_out_valid  (res_ch.valid),
        .i_out_ready  (res_ch.ready),
        .i_sig_ok     (res_ch.sig_ok),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_ok_count   (ok_count),
        .o_bad_count  (bad_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Integer lengths lean short, with the widest ones now and then
    function automatic int pick_int_len();
        int r;
        r = $urandom_range(9);
        if (r < 6) return $urandom_range(1, 4);
        if (r < 9) return $urandom_range(5, 31);
        return $urandom_range(32, 33);
    endfunction

    // Append one strictly encoded INTEGER of the given length
    function automatic void append_integer(ref t_byte sig[$], input int len);
        t_byte lead;
        lead = ($urandom_range(3) == 0) ? 8'h00 : t_byte'($urandom_range(8'h7f));
        if (len == int'(INT_LEN_MAX)) lead = 8'h00;
        sig.push_back(TAG_INTEGER);
        sig.push_back(t_byte'(len));
        sig.push_back(lead);
        for (int i = 1; i < len; i++) begin
            if (i == 1 && lead == 8'h00) sig.push_back(8'h80 | t_byte'($urandom_range(255)));
            else sig.push_back(t_byte'($urandom_range(255)));
        end
    endfunction

    function automatic void build_valid(ref t_byte sig[$], input int len_r, input int len_s);
        sig.delete();
        sig.push_back(TAG_SEQUENCE);
        sig.push_back(8'h00);
        append_integer(sig, len_r);
        append_integer(sig, len_s);
        sig[1] = t_byte'(sig.size() - 2);
    endfunction

    // Hand a signature to the sender, marking its last byte
    function automatic void queue_signature(ref t_byte sig[$]);
        t_sig_item item;
        foreach (sig[i]) begin
            item.value = sig[i];
            item.last  = (i == sig.size() - 1);
            byte_stream.push_back(item);
        end
        sig_total  = sig_total + 1;
        byte_total = byte_total + sig.size();
    endfunction

    // Mostly well-formed signatures, then spoilt ones, then plain noise
    function automatic void queue_random_signature();
        t_byte sig[$];
        int    len_r;
        int    len_s;
        int    pick;
        int    tag_at;
        int    len_of;
        int    n;
        t_flaw flaw;
        len_r = pick_int_len();
        len_s = pick_int_len();
        build_valid(sig, len_r, len_s);
        pick = $urandom_range(99);
        if (pick >= 55 && pick < 88) begin
            if ($urandom_range(1) == 1) begin
                tag_at = 4 + len_r;
                len_of = len_s;
            end else begin
                tag_at = 2;
                len_of = len_r;
            end
            flaw = t_flaw'($urandom_range(FLAW_OVERLONG));
            case (flaw)
                FLAW_SEQ_TAG: sig[0] = TAG_SEQUENCE ^ t_byte'($urandom_range(1, 255));
                FLAW_SEQ_LEN: begin
                    n = $urandom_range(2);
                    if (n == 0) sig[1] = sig[1] + 8'h01;
                    else if (n == 1) sig[1] = sig[1] - 8'h01;
                    else sig[1] = t_byte'($urandom_range(8'h7f));
                end
                FLAW_LONG_FORM: sig[1] = 8'h80 | t_byte'($urandom_range(255));
                FLAW_INT_TAG: sig[tag_at] = TAG_INTEGER ^ t_byte'($urandom_range(1, 255));
                FLAW_INT_LEN: begin
                    if ($urandom_range(1) == 1) sig[tag_at + 1] = 8'h00;
                    else sig[tag_at + 1] = t_byte'($urandom_range(34, 255));
                end
                FLAW_NEGATIVE: sig[tag_at + 2] = sig[tag_at + 2] | 8'h80;
                FLAW_PADDING: begin
                    sig[tag_at + 2] = 8'h00;
                    if (len_of > 1) sig[tag_at + 3] = sig[tag_at + 3] & 8'h7f;
                end
                FLAW_WIDE_LEAD: begin
                    build_valid(sig, int'(INT_LEN_MAX), len_s);
                    sig[4] = t_byte'($urandom_range(1, 255));
                end
                FLAW_TRUNCATE: begin
                    n = $urandom_range(sig.size() - 2);
                    while (sig.size() > n + 1) void'(sig.pop_back());
                end
                FLAW_TRAILING: begin
                    repeat ($urandom_range(1, 4)) sig.push_back(t_byte'($urandom_range(255)));
                    if ($urandom_range(1) == 1) sig[1] = t_byte'(sig.size() - 2);
                end
                FLAW_OVERLONG: begin
                    build_valid(sig, int'(INT_LEN_MAX), int'(INT_LEN_MAX));
                    n = $urandom_range(int'(MAX_SIG_BYTES) + 1, 130);
                    while (sig.size() < n) sig.push_back(t_byte'($urandom_range(255)));
                end
                default: ;
            endcase
        end else if (pick >= 88) begin
            sig.delete();
            n = ($urandom_range(9) == 0) ? $urandom_range(73, 140) : $urandom_range(1, 12);
            repeat (n) sig.push_back(t_byte'($urandom_range(255)));
            if ($urandom_range(1) == 1) sig[0] = TAG_SEQUENCE;
        end
        queue_signature(sig);
    endfunction

    // Sender: offer the next byte, at random, when the slot is free
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            sig_ch.valid <= 1'b0;
        end else if (!sig_ch.valid || sig_ch.ready) begin
            if (byte_stream.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
                sig_ch.valid      <= 1'b1;
                sig_ch.sig_byte   <= byte_stream[0].value;
                sig_ch.final_byte <= byte_stream[0].last;
                void'(byte_stream.pop_front());
            end else begin
                sig_ch.valid <= 1'b0;
            end
        end
    end

    // Receiver: stall at random
    always @(posedge i_clk) begin
        if (!i_rst_n) res_ch.ready <= 1'b0;
        else res_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
    end

    // Watchdog: give up when nothing moves for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (sig_ch.valid && sig_ch.ready) || (res_ch.valid && res_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == QUIET_LIMIT) begin
            $display("tb: failure");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        t_byte sig[$];
        i_rst_n <= 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: smallest strict signature with extreme body values
        sig = '{TAG_SEQUENCE, 8'h06, TAG_INTEGER, 8'h01, 8'h00, TAG_INTEGER, 8'h01, 8'h7f};
        queue_signature(sig);
        // bad opening tag; the bytes after it must not revive the parse
        sig = '{8'hff, TAG_SEQUENCE, 8'h06};
        queue_signature(sig);
        // long-form sequence length
        sig = '{TAG_SEQUENCE, 8'h81, TAG_INTEGER};
        queue_signature(sig);
        // stream ends before the integers
        sig = '{TAG_SEQUENCE, 8'h06};
        queue_signature(sig);
        // one byte too many after the second integer
        sig = '{TAG_SEQUENCE, 8'h06, TAG_INTEGER, 8'h01, 8'h01, TAG_INTEGER, 8'h01, 8'h01,
                8'h00};
        queue_signature(sig);

        // Random, paced three ways
        while (byte_total < 408) queue_random_signature();
        while (byte_stream.size() != 0) @(negedge i_clk);
        src_idle_pct = 52;
        snk_idle_pct = 29;
        while (byte_total < 792) queue_random_signature();
        while (byte_stream.size() != 0) @(negedge i_clk);
        src_idle_pct = 0;
        snk_idle_pct = 0;
        while (byte_total < 1175) queue_random_signature();

        // Drain: all bytes moved and every verdict returned
        while (byte_stream.size() != 0 || sig_ch.valid || pending != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);

        $display("summary: %0d signatures in %0d bytes under three pacing mixes", sig_total,
                 byte_total);
        $display("summary: %0d judged strictly well formed, %0d rejected", ok_count,
                 bad_count);
        if (fail_count == 0 && pending == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
